/* hw/rtl/dtt_pkg.sv */
`default_nettype none
package dtt_pkg;

    localparam int SPAN_W  = 9;
    localparam int IDX_W   = 8;
    localparam int COORD_W = 13;
    localparam int VIS_W   = 11;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_X  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y  = 3'd4;

    typedef enum logic [1:0] {
        REQ_MARK  = 2'd0,
        REQ_MERGE = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef struct packed {
        t_req              op;
        logic [SPAN_W-1:0] x0;
        logic [SPAN_W-1:0] x1;
        logic [SPAN_W-1:0] y0;
        logic [SPAN_W-1:0] y1;
        logic [IDX_W-1:0]  col;
        logic [IDX_W-1:0]  row;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_RSRC,
        S_RTGT,
        S_WR,
        S_RREAD,
        S_RPICK,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

/* hw/rtl/dtt_front.sv */
`default_nettype none
module dtt_front
    import dtt_pkg::*;
#(
    parameter int GRID_TILES = 256,
    parameter int TILE_SHIFT = 3
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [VIS_W-1:0]     i_cfg_data,
    input  wire logic                 i_valid,
    input  wire logic [1:0]           i_req_type,
    input  wire logic [COORD_W-1:0]   i_rect_left,
    input  wire logic [COORD_W-1:0]   i_rect_top,
    input  wire logic [COORD_W-1:0]   i_rect_right,
    input  wire logic [COORD_W-1:0]   i_rect_bottom,
    input  wire logic [IDX_W-1:0]     i_query_col,
    input  wire logic [IDX_W-1:0]     i_query_row,
    input  wire logic                 i_full,
    output logic                      o_stall,
    output logic                      o_push,
    output t_cmd                      o_cmd
);

    localparam logic [13:0] GRID14 = 14'(GRID_TILES);
    localparam logic signed [13:0] TILE14 = 14'(1 << TILE_SHIFT);

    logic             r_enable;
    logic [VIS_W-1:0] r_min_x, r_max_x, r_min_y, r_max_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
            r_min_x  <= '0;
            r_max_x  <= '1;
            r_min_y  <= '0;
            r_max_y  <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE: r_enable <= i_cfg_data[0];
                CFG_MIN_X:  r_min_x  <= i_cfg_data;
                CFG_MAX_X:  r_max_x  <= i_cfg_data;
                CFG_MIN_Y:  r_min_y  <= i_cfg_data;
                CFG_MAX_Y:  r_max_y  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    function automatic logic [SPAN_W-1:0] clamp_grid(input logic [13:0] v);
        if (v > GRID14) begin
            return SPAN_W'(GRID_TILES);
        end
        return v[SPAN_W-1:0];
    endfunction

    function automatic logic [SPAN_W-1:0] lo_end(input logic [COORD_W-1:0] c,
                                                 input logic [VIS_W-1:0] m);
        logic signed [13:0] a;
        logic signed [13:0] b;
        logic [13:0]        v;
        a = $signed({c[COORD_W-1], c});
        b = $signed({3'b000, m});
        v = (a < b) ? b : a;
        return clamp_grid(v >> TILE_SHIFT);
    endfunction

    function automatic logic [SPAN_W-1:0] hi_end(input logic [COORD_W-1:0] c,
                                                 input logic [VIS_W-1:0] m);
        logic signed [13:0] a;
        logic signed [13:0] b;
        logic signed [13:0] t;
        a = $signed({c[COORD_W-1], c});
        b = $signed({3'b000, m});
        t = ((a > b) ? b : a) + TILE14;
        if (t <= 14'sd0) begin
            return '0;
        end
        return clamp_grid(14'(t) >> TILE_SHIFT);
    endfunction

    t_req req;

    always_comb begin
        req          = t_req'(i_req_type);
        o_stall      = i_full;
        o_push       = i_valid && !i_full;
        o_cmd.op     = req;
        o_cmd.col    = i_query_col;
        o_cmd.row    = i_query_row;
        o_cmd.x0     = '0;
        o_cmd.x1     = '0;
        o_cmd.y0     = '0;
        o_cmd.y1     = '0;
        case (req)
            REQ_MARK: begin
                if (r_enable) begin
                    o_cmd.x0 = lo_end(i_rect_left, r_min_x);
                    o_cmd.x1 = hi_end(i_rect_right, r_max_x);
                    o_cmd.y0 = lo_end(i_rect_top, r_min_y);
                    o_cmd.y1 = hi_end(i_rect_bottom, r_max_y);
                end
            end
            REQ_MERGE: begin
                o_cmd.x0 = clamp_grid(14'(r_min_x) >> TILE_SHIFT);
                o_cmd.x1 = clamp_grid(14'(r_max_x) >> TILE_SHIFT);
                o_cmd.y0 = clamp_grid(14'(r_min_y) >> TILE_SHIFT);
                o_cmd.y1 = clamp_grid(14'(r_max_y) >> TILE_SHIFT);
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

/* hw/rtl/dtt_queue.sv */
`default_nettype none
module dtt_queue
    import dtt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_cmd      o_cmd
);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_q[r_rp];

endmodule
`default_nettype wire

/* hw/rtl/dtt_back.sv */
`default_nettype none
module dtt_back
    import dtt_pkg::*;
#(
    parameter int GRID_TILES = 256
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_empty,
    input  wire t_cmd i_cmd,
    output logic      o_pop,
    input  wire logic i_stall,
    output logic      o_valid,
    output logic      o_tile_dirty,
    output logic      o_row_dirty
);

    localparam int RW = $clog2(GRID_TILES);
    localparam int AW = RW + 1;

    logic [GRID_TILES-1:0] mem [2*GRID_TILES];
    logic [GRID_TILES-1:0] r_rdata;
    logic [1:0][GRID_TILES-1:0] r_flag;

    t_state                r_state, n_state;
    t_cmd                  r_cmd;
    logic [GRID_TILES-1:0] r_mask, r_src, head_mask;
    logic [SPAN_W-1:0]     r_y;
    logic                  r_bank;
    logic                  r_res_tile, r_res_row;
    logic                  r_out_valid, r_out_tile, r_out_row;

    logic [RW-1:0]         yi;
    logic                  tb;
    logic                  is_merge;
    logic [AW-1:0]         rd_addr;
    logic                  we;
    logic [GRID_TILES-1:0] wdata;
    logic                  q_in_range;

    assign yi       = r_y[RW-1:0];
    assign is_merge = (r_cmd.op == REQ_MERGE);
    assign tb       = is_merge ? ~r_bank : r_bank;
    assign q_in_range = ({1'b0, r_cmd.col} < (IDX_W+1)'(GRID_TILES))
                     && ({1'b0, r_cmd.row} < (IDX_W+1)'(GRID_TILES));

    always_comb begin
        for (int k = 0; k < GRID_TILES; k++) begin
            head_mask[k] = (SPAN_W'(k) >= i_cmd.x0) && (SPAN_W'(k) < i_cmd.x1);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_empty && !r_out_valid) begin
                    case (i_cmd.op)
                        REQ_MARK, REQ_MERGE: n_state = S_ROW;
                        REQ_READ:            n_state = S_RREAD;
                        default:             n_state = S_DONE;
                    endcase
                end
            end
            S_ROW: begin
                if (r_y >= r_cmd.y1) begin
                    n_state = S_DONE;
                end else if (!is_merge) begin
                    n_state = S_RTGT;
                end else if (r_flag[r_bank][yi]) begin
                    n_state = S_RSRC;
                end
            end
            S_RSRC:  n_state = S_RTGT;
            S_RTGT:  n_state = S_WR;
            S_WR:    n_state = S_ROW;
            S_RREAD: n_state = S_RPICK;
            S_RPICK: n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop   = 1'b0;
        we      = 1'b0;
        rd_addr = {tb, yi};
        wdata   = (r_flag[tb][yi] ? r_rdata : '0) | r_src;
        case (r_state)
            S_IDLE:  o_pop   = !i_empty && !r_out_valid;
            S_RSRC:  rd_addr = {r_bank, yi};
            S_RTGT:  rd_addr = {tb, yi};
            S_WR:    we      = 1'b1;
            S_RREAD: rd_addr = {r_bank, r_cmd.row[RW-1:0]};
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[rd_addr];
        if (we) begin
            mem[{tb, yi}] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_flag      <= '0;
            r_bank      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_WR) begin
                r_flag[tb][yi] <= 1'b1;
            end
            if (r_state == S_ROW && r_y >= r_cmd.y1 && is_merge) begin
                r_bank <= ~r_bank;
            end
            if (r_state == S_DONE) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cmd      <= i_cmd;
                r_mask     <= head_mask;
                r_src      <= head_mask;
                r_y        <= i_cmd.y0;
                r_res_tile <= 1'b0;
                r_res_row  <= 1'b0;
            end
            S_ROW: begin
                if (r_y < r_cmd.y1 && is_merge && !r_flag[r_bank][yi]) begin
                    r_y <= r_y + 1'b1;
                end
            end
            S_RTGT: begin
                if (is_merge) begin
                    r_src <= r_rdata & r_mask;
                end
            end
            S_WR: r_y <= r_y + 1'b1;
            S_RPICK: begin
                r_res_row  <= q_in_range && r_flag[r_bank][r_cmd.row[RW-1:0]];
                r_res_tile <= q_in_range && r_flag[r_bank][r_cmd.row[RW-1:0]]
                              && r_rdata[r_cmd.col[RW-1:0]];
            end
            S_DONE: begin
                r_out_tile <= r_res_tile;
                r_out_row  <= r_res_row;
            end
            default: ;
        endcase
    end

    assign o_valid      = r_out_valid;
    assign o_tile_dirty = r_out_tile;
    assign o_row_dirty  = r_out_row;

    a_pop_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !r_out_valid)
        else $error("pop while result pending");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> r_out_valid)
        else $error("result lost after done");
    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> (r_y < r_cmd.y1))
        else $error("row write beyond span");
    a_flag_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |=> r_flag[$past(tb)][$past(yi)])
        else $error("row flag not set after write");

endmodule
`default_nettype wire

/* hw/rtl/dirty_tile_tracker_top.sv */
`default_nettype none
// Dirty tile tracker with two banks of tile maps held in one memory of
// 2*GRID_TILES rows, plus per-row flags in flops. Requests queue two deep
// behind the front end. A mark steps through each tile row of the clipped
// span in S_ROW, S_RTGT and S_WR; a merge reads the source row, then the
// target row, then writes, for each dirty row of the visible span, and skips
// clean rows. Both are bound by the read-modify-write of each full tile row
// through a memory with a registered read. A read passes S_RREAD and S_RPICK.
// Row flags mask never-written rows, so no clearing pass runs after reset.
module dirty_tile_tracker_top
    import dtt_pkg::*;
#(
    parameter int GRID_TILES = 256,
    parameter int TILE_SHIFT = 3
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [VIS_W-1:0]     i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [1:0]           i_req_type,
    input  wire logic [COORD_W-1:0]   i_rect_left,
    input  wire logic [COORD_W-1:0]   i_rect_top,
    input  wire logic [COORD_W-1:0]   i_rect_right,
    input  wire logic [COORD_W-1:0]   i_rect_bottom,
    input  wire logic [IDX_W-1:0]     i_query_col,
    input  wire logic [IDX_W-1:0]     i_query_row,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic                      o_tile_dirty,
    output logic                      o_row_dirty
);

    t_cmd push_cmd, head_cmd;
    logic push, pop, full, empty;

    dtt_front #(.GRID_TILES(GRID_TILES), .TILE_SHIFT(TILE_SHIFT)) u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data, .i_valid,
        .i_req_type, .i_rect_left, .i_rect_top, .i_rect_right, .i_rect_bottom,
        .i_query_col, .i_query_row,
        .i_full(full), .o_stall, .o_push(push), .o_cmd(push_cmd)
    );

    dtt_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_cmd(push_cmd), .i_pop(pop),
        .o_full(full), .o_empty(empty), .o_cmd(head_cmd)
    );

    dtt_back #(.GRID_TILES(GRID_TILES)) u_back (
        .i_clk, .i_rst_n, .i_empty(empty), .i_cmd(head_cmd), .o_pop(pop),
        .i_stall, .o_valid, .o_tile_dirty, .o_row_dirty
    );

endmodule
`default_nettype wire
